### hw/rtl/bfla_pkg.sv
`timescale 1ns / 1ps

package bfla_pkg;

  localparam int unsigned IdxW            = 10;
  localparam int unsigned NextW           = 11;
  localparam int unsigned MaxBlocksDflt   = 1024;
  localparam int unsigned LinkDepthCap    = 1024;
  localparam int unsigned ApbDataW        = 32;
  localparam int unsigned ApbAddrW        = 3;

  localparam logic [IdxW-1:0]  BlockCountRst = 10'd1023;
  localparam logic [NextW-1:0] NextUnusedRst = 11'd1;

  typedef enum logic {
    RegBlockCount = 1'b0
  } reg_idx_e;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusFull    = 2'd1,
    StatusInvalid = 2'd2
  } status_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] granted_block;
    status_e         status;
  } rsp_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } link_req_t;

endpackage

### hw/rtl/bfla_cfg.sv
`timescale 1ns / 1ps

module bfla_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bfla_pkg::ApbAddrW-1:0]      paddr,
  input  logic [bfla_pkg::ApbDataW-1:0]      pwdata,
  output logic [bfla_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  output logic [bfla_pkg::IdxW-1:0]          block_count_o
);

  logic [bfla_pkg::IdxW-1:0] block_count_q;
  logic                      sel_bc;

  assign sel_bc = (bfla_pkg::reg_idx_e'(paddr[2]) == bfla_pkg::RegBlockCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= bfla_pkg::BlockCountRst;
    end else if (psel && penable && pwrite && sel_bc) begin
      block_count_q <= pwdata[bfla_pkg::IdxW-1:0];
    end
  end

  assign pready        = 1'b1;
  assign prdata        = sel_bc ? bfla_pkg::ApbDataW'(block_count_q) : '0;
  assign block_count_o = block_count_q;

endmodule

### hw/rtl/bfla_link_ram.sv
`timescale 1ns / 1ps

module bfla_link_ram #(
  parameter int unsigned Depth = bfla_pkg::LinkDepthCap,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  bfla_pkg::link_req_t       req_i,
  output logic [bfla_pkg::IdxW-1:0] rdata_o
);

  logic [bfla_pkg::IdxW-1:0] mem [Depth];
  logic [bfla_pkg::IdxW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AddrW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AddrW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bfla_ctrl.sv
`timescale 1ns / 1ps

module bfla_ctrl #(
  parameter int unsigned MAX_BLOCKS = bfla_pkg::MaxBlocksDflt
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bfla_pkg::req_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bfla_pkg::rsp_t            out_data_o,
  input  logic [bfla_pkg::IdxW-1:0] block_count_i,
  output bfla_pkg::link_req_t       link_req_o,
  input  logic [bfla_pkg::IdxW-1:0] link_rdata_i
);

  typedef enum logic {
    StIdle,
    StFinish
  } state_e;

  typedef enum logic [1:0] {
    KindList,
    KindBump,
    KindFree,
    KindNone
  } kind_e;

  state_e                     state_q;
  kind_e                      kind_q, kind_d;
  logic                       out_valid_q;
  bfla_pkg::rsp_t             out_data_q;
  bfla_pkg::rsp_t             res_q, res_d;
  logic [bfla_pkg::IdxW-1:0]  idx_q;
  logic [bfla_pkg::IdxW-1:0]  head_q;
  logic [bfla_pkg::IdxW-1:0]  tail_q;
  logic [bfla_pkg::NextW-1:0] next_q;

  logic accept, advance, list_hit, store_full, bad_free;

  assign accept  = (state_q == StIdle) && in_valid_i;
  assign advance = (state_q == StFinish) && (!out_valid_q || out_ready_i);

  assign list_hit   = (head_q != '0) && (32'(head_q) < 32'(MAX_BLOCKS));
  assign store_full = (next_q > {1'b0, block_count_i}) ||
                      (32'(next_q) >= 32'(MAX_BLOCKS));
  assign bad_free   = (in_data_i.block_index == '0) ||
                      ({1'b0, in_data_i.block_index} >= next_q) ||
                      (32'(in_data_i.block_index) >= 32'(MAX_BLOCKS));

  always_comb begin
    kind_d = KindNone;
    res_d  = '{granted_block: '0, status: bfla_pkg::StatusOk};
    if (in_data_i.op == bfla_pkg::OpAlloc) begin
      if (list_hit) begin
        kind_d              = KindList;
        res_d.granted_block = head_q;
      end else if (store_full) begin
        res_d.status = bfla_pkg::StatusFull;
      end else begin
        kind_d              = KindBump;
        res_d.granted_block = next_q[bfla_pkg::IdxW-1:0];
      end
    end else begin
      if (bad_free) begin
        res_d.status = bfla_pkg::StatusInvalid;
      end else begin
        kind_d              = KindFree;
        res_d.granted_block = in_data_i.block_index;
      end
    end
  end

  always_comb begin
    link_req_o       = '0;
    link_req_o.re    = accept && (kind_d == KindList);
    link_req_o.raddr = head_q;
    if (accept && (kind_d == KindFree)) begin
      link_req_o.we    = 1'b1;
      link_req_o.waddr = in_data_i.block_index;
      link_req_o.wdata = '0;
    end else if (advance && (kind_q == KindFree) && (head_q != '0)) begin
      link_req_o.we    = 1'b1;
      link_req_o.waddr = tail_q;
      link_req_o.wdata = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      kind_q      <= KindNone;
      res_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      next_q      <= bfla_pkg::NextUnusedRst;
    end else begin
      if (out_ready_i && !advance) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            kind_q  <= kind_d;
            res_q   <= res_d;
            idx_q   <= in_data_i.block_index;
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (advance) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= StIdle;
            case (kind_q)
              KindList: begin
                head_q <= link_rdata_i;
                if (link_rdata_i == '0) begin
                  tail_q <= '0;
                end
              end
              KindBump: begin
                next_q <= next_q + 1'b1;
              end
              KindFree: begin
                if (head_q == '0) begin
                  head_q <= idx_q;
                end
                tail_q <= idx_q;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/block_free_list_allocator_top.sv
`timescale 1ns / 1ps

// Block allocator over a store of numbered blocks, where index 0 means none.
// An allocate item takes the head of the list of freed blocks, or else the
// next never-used block; a free item appends its block to the list. Each item
// yields one result. On acceptance the link memory is read (allocate from the
// list) or the freed block's link is cleared; in the finishing state the read
// data updates the list head, or the old tail's link is written, and the
// result is loaded into the output register. No new item is taken until the
// last has finished. A result still waiting in the output register holds the
// next item in its finishing state. block_count is written at offset 0 of the
// APB port; status reports 1 when the store is full and 2 for a free of index
// 0 or of a block never handed out.
module block_free_list_allocator_top #(
  parameter int unsigned MAX_BLOCKS = bfla_pkg::MaxBlocksDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bfla_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bfla_pkg::rsp_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfla_pkg::ApbAddrW-1:0] paddr,
  input  logic [bfla_pkg::ApbDataW-1:0] pwdata,
  output logic [bfla_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned LinkDepth = (MAX_BLOCKS < bfla_pkg::LinkDepthCap) ?
                                      MAX_BLOCKS : bfla_pkg::LinkDepthCap;
  localparam int unsigned LinkAddrW = $clog2(LinkDepth);

  logic [bfla_pkg::IdxW-1:0] block_count;
  logic [bfla_pkg::IdxW-1:0] link_rdata;
  bfla_pkg::link_req_t       link_req;

  bfla_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .block_count_o (block_count)
  );

  bfla_link_ram #(
    .Depth (LinkDepth),
    .AddrW (LinkAddrW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  bfla_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .block_count_i (block_count),
    .link_req_o    (link_req),
    .link_rdata_i  (link_rdata)
  );

endmodule

### hw/rtl/bfla_checker.sv
`timescale 1ns / 1ps

module bfla_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input bfla_pkg::rsp_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new item taken while the previous one is in progress");

  a_error_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != bfla_pkg::StatusOk)
      |-> out_data_i.granted_block == '0)
    else $error("error result carries a block index");

  a_ok_has_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == bfla_pkg::StatusOk)
      |-> out_data_i.granted_block != '0)
    else $error("successful result carries block index zero");

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without an item two cycles before");

endmodule

bind block_free_list_allocator_top bfla_checker u_bfla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

### sim/bfla_grant_checker.sv
`timescale 1ns / 1ps

module bfla_grant_checker
  import bfla_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  req_t                in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  rsp_t                out_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic [ApbDataW-1:0] prdata_i,
  input  logic                pready_i,
  output int                  mismatches_o,
  output int                  grants_pending_o
);

  localparam logic [ApbAddrW-1:0] BlockCountAddr = ApbAddrW'(4 * RegBlockCount);
  localparam int unsigned MaxBlocks = MaxBlocksDflt;

  logic [IdxW-1:0]  block_count;
  logic [IdxW-1:0]  list_head;
  logic [IdxW-1:0]  list_tail;
  logic [NextW-1:0] next_fresh;
  logic [IdxW-1:0]  block_link [MaxBlocks];
  rsp_t             expected_grants [$];

  // Freed blocks form a FIFO list threaded through block_link; fresh blocks
  // come from next_fresh once that list is empty.
  function automatic rsp_t predict_grant(req_t req);
    rsp_t r;
    r.granted_block = '0;
    r.status        = StatusOk;
    if (req.op == OpAlloc) begin
      if (list_head != '0) begin
        r.granted_block = list_head;
        list_head = block_link[list_head];
        if (list_head == '0) begin
          list_tail = '0;
        end
      end else if (next_fresh > NextW'(block_count) || next_fresh >= NextW'(MaxBlocks)) begin
        r.status = StatusFull;
      end else begin
        r.granted_block = next_fresh[IdxW-1:0];
        next_fresh = next_fresh + 1'b1;
      end
    end else begin
      if (req.block_index == '0 || NextW'(req.block_index) >= next_fresh) begin
        r.status = StatusInvalid;
      end else begin
        block_link[req.block_index] = '0;
        if (list_head == '0) begin
          list_head = req.block_index;
        end else begin
          block_link[list_tail] = req.block_index;
        end
        list_tail = req.block_index;
        r.granted_block = req.block_index;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatches_o < 10) begin
      $display("%s", msg);
    end
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      block_count = BlockCountRst;
      list_head   = '0;
      list_tail   = '0;
      next_fresh  = NextUnusedRst;
      expected_grants.delete();
      mismatches_o     = 0;
      grants_pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_grants.size() == 0) begin
          note_mismatch($sformatf("%0t: result with no item pending: block %0d status %0d",
                                  $time, out_data_i.granted_block, out_data_i.status));
        end else begin
          want = expected_grants.pop_front();
          if (out_data_i.granted_block !== want.granted_block) begin
            note_mismatch($sformatf("%0t: granted_block expected %0d got %0d",
                                    $time, want.granted_block, out_data_i.granted_block));
          end
          if (out_data_i.status !== want.status) begin
            note_mismatch($sformatf("%0t: status expected %0d got %0d",
                                    $time, want.status, out_data_i.status));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_grants.push_back(predict_grant(in_data_i));
      end
      if (psel_i && penable_i && pready_i && paddr_i == BlockCountAddr) begin
        if (pwrite_i) begin
          block_count = pwdata_i[IdxW-1:0];
        end else if (prdata_i[IdxW-1:0] !== block_count) begin
          note_mismatch($sformatf("%0t: block_count read expected %0d got %0d",
                                  $time, block_count, prdata_i[IdxW-1:0]));
        end
      end
      grants_pending_o = expected_grants.size();
    end
  end

endmodule

### sim/block_free_list_allocator_top_tb.sv
`timescale 1ns / 1ps

module block_free_list_allocator_top_tb;
  import bfla_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam logic [ApbAddrW-1:0] BlockCountAddr = ApbAddrW'(4 * RegBlockCount);
  localparam int unsigned TopIndex = (1 << IdxW) - 1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  req_t                in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rsp_t                out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ApbAddrW-1:0] paddr     = '0;
  logic [ApbDataW-1:0] pwdata    = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int mismatches;
  int grants_pending;

  logic [IdxW-1:0] held_blocks [$];
  op_e             sent_ops [$];
  int unsigned     top_granted = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     rx_hold     = 0;
  bit              calm_tx     = 1'b0;
  bit              calm_rx     = 1'b0;

  always #6 clk = ~clk;

  block_free_list_allocator_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  bfla_grant_checker u_grant_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .pready_i         (pready),
    .mismatches_o     (mismatches),
    .grants_pending_o (grants_pending)
  );

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic void forget_block(logic [IdxW-1:0] idx);
    for (int k = 0; k < held_blocks.size(); k++) begin
      if (held_blocks[k] == idx) begin
        held_blocks.delete(k);
        break;
      end
    end
  endfunction

  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) calm_rx = !calm_rx;
    if (rx_hold != 0) begin
      rx_hold--;
    end else if (calm_rx || $urandom_range(0, 2) != 0) begin
      out_ready = 1'b1;
      rx_hold = $urandom_range(0, 6);
    end else begin
      out_ready = 1'b0;
      rx_hold = pick_pause();
    end
  end

  // Track granted blocks so that most frees name a block that is really held.
  always @(posedge clk) begin
    op_e done_op;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid && out_ready && sent_ops.size() != 0) begin
        done_op = sent_ops.pop_front();
        if (done_op == OpAlloc && out_data.status == StatusOk) begin
          held_blocks.push_back(out_data.granted_block);
          if (out_data.granted_block > top_granted) top_granted = out_data.granted_block;
        end
      end
      if (in_valid && in_ready) begin
        sent_ops.push_back(in_data.op);
      end
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_req(op_e op, logic [IdxW-1:0] idx);
    int unsigned pause;
    pause = calm_tx ? 0 : pick_pause();
    if (op == OpFree) forget_block(idx);
    if (pause != 0) begin
      in_valid = 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_data  = '{op: op, block_index: idx};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (grants_pending != 0) @(negedge clk);
  endtask

  task automatic apb_cycle(bit wr, logic [ApbDataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = BlockCountAddr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_block_count(logic [IdxW-1:0] value);
    settle();
    repeat (2) @(negedge clk);
    apb_cycle(1'b1, ApbDataW'(value));
    apb_cycle(1'b0, '0);
  endtask

  function automatic logic [IdxW-1:0] unissued_index();
    if (top_granted >= TopIndex || $urandom_range(0, 3) == 0) return '0;
    return IdxW'($urandom_range(top_granted + 1, TopIndex));
  endfunction

  task automatic run_phase(int unsigned count, int unsigned alloc_pct);
    int unsigned roll;
    int unsigned k;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 149) == 0) calm_tx = !calm_tx;
      if ($urandom_range(0, 149) == 0) settle();
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_req(OpFree, IdxW'($urandom));
      end else if (roll < 4) begin
        send_req(OpFree, unissued_index());
      end else if (held_blocks.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
        send_req(OpAlloc, IdxW'($urandom));
      end else begin
        k = $urandom_range(0, held_blocks.size() - 1);
        send_req(OpFree, held_blocks[k]);
      end
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Frees of index 0, of a block never handed out and of the top index.
    send_req(OpFree, '0);
    send_req(OpFree, 10'd1);
    send_req(OpFree, 10'd1023);
    send_req(OpAlloc, 10'd1023);
    send_req(OpAlloc, '0);
    send_req(OpAlloc, 10'd512);
    send_req(OpFree, 10'd3);
    send_req(OpFree, 10'd4);
    send_req(OpFree, 10'd2);
    send_req(OpAlloc, 10'd0);
    send_req(OpAlloc, 10'd0);
    send_req(OpAlloc, 10'd0);
    // A double free links the block to itself until another free follows.
    send_req(OpFree, 10'd4);
    send_req(OpFree, 10'd4);
    send_req(OpFree, 10'd1);
    send_req(OpAlloc, 10'd0);
    send_req(OpAlloc, 10'd0);
    set_block_count(10'd4);
    send_req(OpAlloc, 10'd341);
    send_req(OpFree, 10'd4);
    send_req(OpAlloc, 10'd682);
    send_req(OpAlloc, 10'd0);
    set_block_count(10'd0);
    send_req(OpAlloc, 10'd0);
    send_req(OpFree, 10'd5);

    set_block_count(10'd40);
    run_phase(200, 60);
    set_block_count(10'd1);
    run_phase(150, 50);
    set_block_count(IdxW'($urandom_range(2, 1022)));
    run_phase(150, 50);
    set_block_count(10'd1023);
    run_phase(1150, 100);
    set_block_count(IdxW'($urandom_range(1, 1023)));
    run_phase(150, 50);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
